// ===== sv/lps_pkg.sv =====
// shared types and constants for the line pixel stepper
// no dependencies; imported by every module of the block
`default_nettype none

package lps_pkg;

    // coordinate width and error accumulator width
    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int COLOUR_BITS = 32;

    // request codes
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef logic [COORD_BITS-1:0]  coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;
    typedef logic [COLOUR_BITS-1:0] colour_t;

    // normalized line state, major axis rising
    typedef struct packed {
        logic   steep;
        coord_t major_pos;
        coord_t major_end;
        coord_t minor_pos;
        logic   step_down;
        coord_t major_span;
        coord_t minor_span;
        err_t   err;
    } line_t;

endpackage : lps_pkg

`default_nettype wire

// ===== sv/lps_setup.sv =====
// start path: normalizes two endpoints into a line state
// depends on lps_pkg
`default_nettype none

module lps_setup
    import lps_pkg::*;
(
    input  wire coord_t start_x,
    input  wire coord_t start_y,
    input  wire coord_t end_x,
    input  wire coord_t end_y,
    output line_t       line,
    output logic        is_last
);

    coord_t dx;
    coord_t dy;
    logic   steep;
    coord_t a0, b0, a1, b1;
    coord_t maj_s, min_s, maj_e, min_e;

    // absolute spans and steepness
    always_comb
    begin
        dx    = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
        dy    = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
        steep = dy > dx;
    end

    // axis swap for steep lines
    always_comb
    begin
        if (steep)
        begin
            a0 = start_y; b0 = start_x; a1 = end_y; b1 = end_x;
        end
        else
        begin
            a0 = start_x; b0 = start_y; a1 = end_x; b1 = end_y;
        end
    end

    // order endpoints so the major coordinate rises
    always_comb
    begin
        if (a1 < a0)
        begin
            maj_s = a1; min_s = b1; maj_e = a0; min_e = b0;
        end
        else
        begin
            maj_s = a0; min_s = b0; maj_e = a1; min_e = b1;
        end
    end

    // packed line state
    always_comb
    begin
        line.steep      = steep;
        line.major_pos  = maj_s;
        line.major_end  = maj_e;
        line.minor_pos  = min_s;
        line.step_down  = !(min_s < min_e);
        line.major_span = steep ? dy : dx;
        line.minor_span = steep ? dx : dy;
        line.err        = '0;
        is_last         = (maj_s == maj_e);
    end

endmodule : lps_setup

`default_nettype wire

// ===== sv/lps_advance.sv =====
// advance path: one midpoint step of the current line
// depends on lps_pkg
`default_nettype none

module lps_advance
    import lps_pkg::*;
(
    input  wire line_t cur,
    output line_t      nxt,
    output logic       is_last
);

    err_t   acc_sum;
    err_t   half_span;
    coord_t maj_next;

    // error update and minor step decision
    always_comb
    begin
        maj_next  = cur.major_pos + coord_t'(1);
        acc_sum   = cur.err + $signed({{(ERR_BITS-COORD_BITS){1'b0}}, cur.minor_span});
        half_span = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, (cur.major_span >> 1)});

        nxt           = cur;
        nxt.major_pos = maj_next;
        nxt.err       = acc_sum;
        if (acc_sum > half_span)
        begin
            nxt.minor_pos = cur.step_down ? (cur.minor_pos - coord_t'(1))
                                          : (cur.minor_pos + coord_t'(1));
            nxt.err       = acc_sum - $signed({{(ERR_BITS-COORD_BITS){1'b0}}, cur.major_span});
        end
        is_last = (maj_next == cur.major_end);
    end

endmodule : lps_advance

`default_nettype wire

// ===== sv/line_pixel_stepper.sv =====
// pixel beats are registered: the beat for an accepted request appears in the cycle after it
// throughput: one request beat per cycle, also while a pixel beat waits if taken
// the pixel register holds one beat; requests stall only while it is full and not taken
// reset clears the active-line flag and the pixel valid flag; advances before a start give nothing
// top level: line state registers, pixel output register; uses lps_setup, lps_advance, lps_pkg
`default_nettype none

module line_pixel_stepper
    import lps_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          req_valid,
    output logic         req_ready,
    input  wire          req_type,
    input  wire coord_t  start_x,
    input  wire coord_t  start_y,
    input  wire coord_t  end_x,
    input  wire coord_t  end_y,
    input  wire colour_t colour,
    output logic         pix_valid,
    input  wire          pix_ready,
    output coord_t       pixel_x,
    output coord_t       pixel_y,
    output colour_t      pixel_colour,
    output logic         last
);

    line_t   line_reg, line_next;
    logic    active_reg, active_next;
    colour_t colour_reg, colour_next;
    logic    valid_reg, valid_next;
    coord_t  px_reg, px_next;
    coord_t  py_reg, py_next;
    colour_t pc_reg, pc_next;
    logic    last_reg, last_next;

    line_t   setup_line;
    logic    setup_last;
    line_t   adv_line;
    logic    adv_last;
    logic    accept;
    logic    emit;

    lps_setup u_setup (
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .line    (setup_line),
        .is_last (setup_last)
    );

    lps_advance u_advance (
        .cur     (line_reg),
        .nxt     (adv_line),
        .is_last (adv_last)
    );

    // handshake
    assign req_ready = !valid_reg || pix_ready;
    assign accept    = req_valid && req_ready;

    // next state and pixel selection
    always_comb
    begin
        line_next   = line_reg;
        active_next = active_reg;
        colour_next = colour_reg;
        emit        = 1'b0;
        last_next   = last_reg;
        if (accept)
        begin
            case (req_type)
                REQ_START:
                begin
                    line_next   = setup_line;
                    colour_next = colour;
                    active_next = !setup_last;
                    last_next   = setup_last;
                    emit        = 1'b1;
                end
                REQ_ADVANCE:
                begin
                    if (active_reg)
                    begin
                        line_next   = adv_line;
                        active_next = !adv_last;
                        last_next   = adv_last;
                        emit        = 1'b1;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        px_next = line_next.steep ? line_next.minor_pos : line_next.major_pos;
        py_next = line_next.steep ? line_next.major_pos : line_next.minor_pos;
        pc_next = colour_next;

        if (emit)
            valid_next = 1'b1;
        else if (pix_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    // line state and pixel payload
    always_ff @(posedge clk)
    begin
        line_reg   <= line_next;
        colour_reg <= colour_next;
        if (emit)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pc_reg   <= pc_next;
            last_reg <= last_next;
        end
    end

    assign pix_valid    = valid_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign pixel_colour = pc_reg;
    assign last         = last_reg;

endmodule : line_pixel_stepper

`default_nettype wire

// ===== sv/lps_checker.sv =====
// port-level checks for line_pixel_stepper, bound to the top level
// depends on lps_pkg
`default_nettype none

module lps_checker
    import lps_pkg::*;
(
    input wire          clk,
    input wire          rst_n,
    input wire          req_valid,
    input wire          req_ready,
    input wire          req_type,
    input wire coord_t  start_x,
    input wire coord_t  start_y,
    input wire coord_t  end_x,
    input wire coord_t  end_y,
    input wire colour_t colour,
    input wire          pix_valid,
    input wire          pix_ready,
    input wire coord_t  pixel_x,
    input wire coord_t  pixel_y,
    input wire colour_t pixel_colour,
    input wire          last
);

    // a start beat always yields a pixel beat carrying its colour
    a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_START
        |=> pix_valid && pixel_colour == $past(colour))
        else $error("start beat gave no pixel or wrong colour");

    // a zero-length line gives its single pixel flagged last
    a_point_line: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_START
            && start_x == end_x && start_y == end_y
        |=> last && pixel_x == $past(start_x) && pixel_y == $past(start_y))
        else $error("zero-length line pixel wrong");

    // an empty output stage never blocks requests
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_valid |-> req_ready)
        else $error("request stalled with empty output");

    // a pixel beat is held until taken
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pixel_x) && $stable(pixel_y))
        else $error("pixel beat dropped or changed while stalled");

endmodule : lps_checker

bind line_pixel_stepper lps_checker u_lps_checker (.*);

`default_nettype wire
